@@ hdl/i2f_pkg.sv @@
package i2f_pkg;

    // field widths of the single-precision format
    localparam int unsigned C_INT_W  = 32;
    localparam int unsigned C_FLT_W  = 32;
    localparam int unsigned C_FRAC_W = 23;
    localparam int unsigned C_EXP_W  = 8;
    localparam int unsigned C_LZ_W   = 5;

    // biased exponent of a value whose top set bit is bit 31
    localparam logic [C_EXP_W-1:0] C_EXP_TOP = 8'd158;

    // normalised magnitude and its leading-zero count
    typedef struct packed {
        logic [C_LZ_W-1:0]  lz;
        logic [C_INT_W-1:0] norm;
    } t_norm;

endpackage

@@ hdl/i2f_norm.sv @@
module i2f_norm
    import i2f_pkg::*;
(
    input  logic [C_INT_W-1:0] i_mag,
    output t_norm              o_norm
);

    logic [C_INT_W-1:0] s16, s8, s4, s2, s1;
    logic               z16, z8, z4, z2, z1;

    // five-step shift search: each step moves the top set bit up by a halving amount
    always_comb begin
        z16 = (i_mag[31:16] == 16'd0);
        s16 = z16 ? {i_mag[15:0], 16'd0} : i_mag;
        z8  = (s16[31:24] == 8'd0);
        s8  = z8 ? {s16[23:0], 8'd0} : s16;
        z4  = (s8[31:28] == 4'd0);
        s4  = z4 ? {s8[27:0], 4'd0} : s8;
        z2  = (s4[31:30] == 2'd0);
        s2  = z2 ? {s4[29:0], 2'd0} : s4;
        z1  = ~s2[31];
        s1  = z1 ? {s2[30:0], 1'b0} : s2;
        o_norm.lz   = {z16, z8, z4, z2, z1};
        o_norm.norm = s1;
    end

endmodule

@@ hdl/i2f_convert.sv @@
module i2f_convert
    import i2f_pkg::*;
(
    input  logic [C_INT_W-1:0] i_int_value,
    output logic [C_FLT_W-1:0] o_float_bits
);

    logic                  sign;
    logic [C_INT_W-1:0]    mag;
    t_norm                 nrm;
    logic [C_FRAC_W+1:0]   sig;
    logic [C_EXP_W-1:0]    expo;
    logic [C_FRAC_W-1:0]   frac;

    // sign and magnitude, most negative value comes out as 2^31
    assign sign = i_int_value[C_INT_W-1];
    assign mag  = sign ? (~i_int_value + 32'd1) : i_int_value;

    i2f_norm u_norm (
        .i_mag  (mag),
        .o_norm (nrm)
    );

    // round to nearest, ties away: add the first dropped bit
    always_comb begin
        sig  = {1'b0, nrm.norm[31:8]} + {{C_FRAC_W+1{1'b0}}, nrm.norm[7]};
        expo = C_EXP_TOP - {3'd0, nrm.lz};
        frac = sig[C_FRAC_W-1:0];
        // carry out of the significand bumps the exponent
        if (sig[C_FRAC_W+1]) begin
            expo = expo + 8'd1;
            frac = '0;
        end
        if (mag == '0) begin
            o_float_bits = '0;
        end else begin
            o_float_bits = {sign, expo, frac};
        end
    end

endmodule

@@ hdl/int_to_float_round.sv @@
// int_to_float_round: signed 32-bit integer to IEEE single-precision bits
//
// input channel: i_in_valid / o_in_stall carry i_in_int_value; a transfer
// happens at a rising edge with valid high and stall low
// output channel: o_out_valid / i_out_stall carry o_out_float_bits, same rule
//
// path: an input transfer fills the input register, the conversion logic works
// on it, and the result register catches the result and offers it as output
// throughput: one item per cycle while the receiver does not stall, set by
// the single conversion pass between the two registers; a new item is taken
// while a result waits
//
// when the receiver stalls the result holds; one more item is taken into
// the input register, after which o_in_stall rises until the result leaves
//
// reset (i_rst_n low, synchronous) empties both registers; the block holds
// no other state. zero gives +0.0, rounding is to nearest with ties away
module int_to_float_round
    import i2f_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [C_INT_W-1:0] i_in_int_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [C_FLT_W-1:0] o_out_float_bits
);

    logic               r_v1, r_v2;
    logic [C_INT_W-1:0] r_x1;
    logic [C_FLT_W-1:0] r_f2, n_f2;
    logic               adv2, take1;

    // result register moves when empty or its transfer completes
    assign adv2       = ~r_v2 | ~i_out_stall;
    assign o_in_stall = r_v1 & ~adv2;
    assign take1      = i_in_valid & ~o_in_stall;

    i2f_convert u_convert (
        .i_int_value  (r_x1),
        .o_float_bits (n_f2)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv2 | ~r_v1) begin
                r_v1 <= i_in_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take1) begin
            r_x1 <= i_in_int_value;
        end
        if (adv2 & r_v1) begin
            r_f2 <= n_f2;
        end
    end

    assign o_out_valid      = r_v2;
    assign o_out_float_bits = r_f2;

endmodule

@@ hdl/i2f_checker.sv @@
module i2f_checker
    import i2f_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_stall,
    input  logic [C_INT_W-1:0] i_in_int_value,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic [C_FLT_W-1:0] o_out_float_bits
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its bits
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_float_bits))
        else $error("result changed while stalled");

    // back-pressure only when a result is held up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // zero converts to +0.0 on the output once the result register is free to take it
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_int_value == 32'd0)
        ##1 (!o_out_valid || !i_out_stall)
        |=> (o_out_valid && o_out_float_bits == 32'd0))
        else $error("zero did not give +0.0");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind int_to_float_round i2f_checker u_i2f_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_in_int_value   (i_in_int_value),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_out_float_bits (o_out_float_bits)
);

@@ sim/tb_int_to_float_round.sv @@
`timescale 1ns / 100ps

module tb_int_to_float_round;
    import i2f_pkg::*;

    localparam int unsigned C_BIAS       = 127;
    localparam int          C_RAND_ITEMS = 900;
    localparam int          C_DRAIN      = 12;
    localparam int          C_HOLD_OFF   = 80;

    // one row of directed stimulus; result is used only where known is set
    typedef struct packed {
        logic [C_INT_W-1:0] value;
        logic               known;
        logic [C_FLT_W-1:0] result;
    } t_row;

    localparam int C_ROWS = 18;
    localparam t_row C_DIR_ROWS [0:C_ROWS-1] = '{
        '{32'h0000_0000, 1'b1, 32'h0000_0000},                  // zero gives +0.0
        '{32'h0000_0001, 1'b1, 32'h3F80_0000},
        '{32'hFFFF_FFFF, 1'b1, 32'hBF80_0000},
        '{32'h0000_0002, 1'b1, 32'h4000_0000},
        '{32'h7FFF_FFFF, 1'b1, 32'h4F00_0000},                  // largest, carries
        '{32'h8000_0000, 1'b1, {1'b1, C_EXP_TOP, 23'd0}},       // most negative
        '{32'h00FF_FFFF, 1'b1, 32'h4B7F_FFFF},                  // 24 bits exact
        '{32'h01FF_FFFF, 1'b1, 32'h4C00_0000},                  // rounding carry
        '{32'h8000_0001, 1'b0, 32'h0},
        '{32'h0100_0000, 1'b0, 32'h0},
        '{32'h0100_0001, 1'b0, 32'h0},                          // tie, away from zero
        '{32'hFF00_0001, 1'b0, 32'h0},
        '{32'h0080_0000, 1'b0, 32'h0},
        '{32'h7FFF_FFC0, 1'b0, 32'h0},
        '{32'h7FFF_FF7F, 1'b0, 32'h0},
        '{32'h1234_5678, 1'b0, 32'h0},
        '{32'hAAAA_AAAA, 1'b0, 32'h0},
        '{32'h5555_5555, 1'b0, 32'h0}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [C_INT_W-1:0] in_int_value;
    logic               out_valid;
    logic               out_stall;
    logic [C_FLT_W-1:0] out_float_bits;

    logic [C_FLT_W-1:0] float_q [$];
    int                 fail_count;
    int                 hold_cycles;
    bit                 send_idle_on;
    bit                 recv_idle_on;

    int_to_float_round uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_in_int_value   (in_int_value),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_out_float_bits (out_float_bits)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // single-precision bits of a signed integer, nearest with ties away
    function automatic logic [C_FLT_W-1:0] single_from_int(input logic [C_INT_W-1:0] x);
        logic               sgn;
        logic [C_INT_W-1:0] mag;
        int                 top;
        int                 sh;
        logic [24:0]        sig;
        logic [C_EXP_W-1:0] ex;
        sgn = x[C_INT_W-1];
        mag = sgn ? (~x + 32'd1) : x;
        if (mag == '0)
            return '0;
        top = 0;
        for (int i = 0; i < C_INT_W; i++)
            if (mag[i])
                top = i;
        ex = C_EXP_W'(C_BIAS + top);
        if (top <= C_FRAC_W) begin
            sig = 25'(mag << (C_FRAC_W - top));
        end else begin
            sh  = top - C_FRAC_W;
            sig = 25'(mag >> sh) + 25'(mag[sh-1]);
            // carry out of the significand bumps the exponent
            if (sig[24]) begin
                sig = sig >> 1;
                ex  = ex + 1'b1;
            end
        end
        return {sgn, ex, sig[C_FRAC_W-1:0]};
    endfunction

    // random integer aimed at small sizes, ties and carries as well as full range
    function automatic logic [C_INT_W-1:0] pick_value();
        logic [C_INT_W-1:0] v;
        int                 sh;
        v  = $urandom;
        sh = $urandom_range(31, 0);
        case ($urandom_range(3, 0))
            0: ;
            1: v = v >> sh;
            2: begin
                // round bit set, bits below clear
                v = v >> $urandom_range(7, 0);
                v[sh % 8] = 1'b1;
                for (int i = 0; i < 8; i++)
                    if (i < sh % 8)
                        v[i] = 1'b0;
            end
            default: v = ~32'd0 >> $urandom_range(8, 0) << $urandom_range(3, 0);
        endcase
        if ($urandom_range(1, 0))
            v = ~v + 32'd1;
        return v;
    endfunction

    // offer one item from a falling edge and wait for its transfer
    task automatic send_item(input logic [C_INT_W-1:0] v, input logic [C_FLT_W-1:0] res);
        while (send_idle_on && $urandom_range(99, 0) < 33) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        in_int_value <= v;
        do
            @(posedge clk);
        while (in_stall);
        float_q.push_back(res);
        @(negedge clk);
    endtask

    // receiver stall: long hold-off when asked, else random
    initial begin
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_stall   <= 1'b1;
                hold_cycles <= hold_cycles - 1;
            end else begin
                out_stall <= recv_idle_on && ($urandom_range(99, 0) < 33);
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (float_q.size() == 0) begin
                $error("float_bits: unexpected result, actual %h", out_float_bits);
                fail_count++;
            end else if (out_float_bits !== float_q[0]) begin
                $error("float_bits mismatch: expected %h, actual %h",
                       float_q[0], out_float_bits);
                fail_count++;
                void'(float_q.pop_front());
            end else begin
                void'(float_q.pop_front());
            end
        end
    end

    // stimulus
    initial begin
        logic [C_INT_W-1:0] v;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_int_value = '0;
        out_stall    = 1'b0;
        fail_count   = 0;
        hold_cycles  = 0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int r = 0; r < C_ROWS; r++)
            send_item(C_DIR_ROWS[r].value,
                      C_DIR_ROWS[r].known ? C_DIR_ROWS[r].result
                                          : single_from_int(C_DIR_ROWS[r].value));

        // random part
        for (int n = 0; n < C_RAND_ITEMS; n++) begin
            // back-to-back stretch on both sides
            send_idle_on = !(n >= 300 && n < 500);
            recv_idle_on = send_idle_on;
            if (n == 100 || n == 700)
                hold_cycles = C_HOLD_OFF;
            // sender pause until every result is back
            if (n == 600) begin
                in_valid <= 1'b0;
                while (float_q.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            v = pick_value();
            send_item(v, single_from_int(v));
        end
        in_valid <= 1'b0;

        // drain
        while (float_q.size() != 0)
            @(posedge clk);
        repeat (C_DRAIN) @(posedge clk);
        if (float_q.size() != 0) begin
            $error("float_bits: %0d expected results never arrived", float_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
